[rtl/bpgc_pkg.sv]
package bpgc_pkg;

    // sizes of the button and subscriber tables
    localparam int BUTTONS     = 2;
    localparam int SUBSCRIBERS = 4;
    localparam int BTN_W       = 1;
    localparam int SLOT_W      = 2;
    localparam int TICK_W      = 16;

    // item kinds
    localparam logic KIND_PIN = 1'b0;
    localparam logic KIND_SUB = 1'b1;

    // reply kinds
    localparam logic [1:0] REPLY_GESTURE = 2'd0;
    localparam logic [1:0] REPLY_GRANT   = 2'd1;
    localparam logic [1:0] REPLY_FULL    = 2'd2;

    // gesture codes
    localparam logic GEST_SHORT = 1'b0;
    localparam logic GEST_LONG  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [1:0] CFG_SHORT    = 2'd1;
    localparam logic [1:0] CFG_LONG     = 2'd2;

    // register reset values
    localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd10;
    localparam logic [TICK_W-1:0] SHORT_RST    = 16'd700;
    localparam logic [TICK_W-1:0] LONG_RST     = 16'd10000;

    typedef struct packed {
        logic              kind;
        logic [1:0]        pin_levels;
        logic [TICK_W-1:0] now_ticks;
        logic              button;
    } t_in;

    typedef struct packed {
        logic [1:0] reply_kind;
        logic [1:0] slot;
        logic       pressed_button;
        logic       gesture;
        logic       last;
    } t_out;

endpackage

[rtl/button_press_gesture_classifier_top.sv]
// Button short / long press classifier.
// Input channel (i_in_valid / o_in_stall / i_in_data) takes pin samples and
// subscribe requests; a beat is taken when valid is high and stall is low.
// Output channel (o_out_valid / i_out_stall / o_out_data) carries replies:
// gesture notifications, subscription grants and table-full replies. The
// last flag marks the final reply caused by one input beat.
// Configuration: i_cfg_we with i_cfg_index / i_cfg_data writes debounce,
// short and long limits; write only while the block is idle.
// One input beat at a time: the input stays stalled until the sequencer is
// idle again. A pin sample checks each button in turn; for each released
// button the hold time is taken and compared with the limits (hold subtract
// and limit compares all run on one shared 17-bit subtractor), and each
// button with a gesture gets a scan of all subscriber slots.
// A stalled output holds its beat; the scan waits when a new reply is ready
// and the output register is still full, so nothing is lost.
// Reset (synchronous, active low) restores the limits to 10/700/10000,
// marks all buttons released and frees every subscriber slot.
module button_press_gesture_classifier_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bpgc_pkg::t_in       i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bpgc_pkg::t_out      o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SUB   = 4'd1;
    localparam logic [3:0] S_BTN   = 4'd2;
    localparam logic [3:0] S_HELD  = 4'd3;
    localparam logic [3:0] S_DEB   = 4'd4;
    localparam logic [3:0] S_SHORT = 4'd5;
    localparam logic [3:0] S_LONG  = 4'd6;
    localparam logic [3:0] S_SCAN  = 4'd7;
    localparam logic [3:0] S_FLUSH = 4'd8;

    localparam logic [bpgc_pkg::BTN_W-1:0]  LAST_BTN =
        bpgc_pkg::BTN_W'(bpgc_pkg::BUTTONS - 1);
    localparam logic [bpgc_pkg::SLOT_W-1:0] LAST_SLOT =
        bpgc_pkg::SLOT_W'(bpgc_pkg::SUBSCRIBERS - 1);

    logic [3:0]                           r_state;
    logic [bpgc_pkg::TICK_W-1:0]          r_debounce;
    logic [bpgc_pkg::TICK_W-1:0]          r_short;
    logic [bpgc_pkg::TICK_W-1:0]          r_long;
    logic [bpgc_pkg::BUTTONS-1:0]         r_last_levels;
    logic [bpgc_pkg::BUTTONS-1:0]         r_levels;
    logic [bpgc_pkg::BUTTONS-1:0]         r_changed;
    logic [bpgc_pkg::TICK_W-1:0]          r_now;
    logic                                 r_want;
    logic [bpgc_pkg::TICK_W-1:0]          r_press_time [bpgc_pkg::BUTTONS];
    logic [bpgc_pkg::SUBSCRIBERS-1:0]     r_sub_valid;
    logic [bpgc_pkg::BTN_W-1:0]           r_sub_button [bpgc_pkg::SUBSCRIBERS];
    logic [bpgc_pkg::BTN_W-1:0]           r_b;
    logic [bpgc_pkg::SLOT_W-1:0]          r_s;
    logic [bpgc_pkg::TICK_W-1:0]          r_held;
    logic                                 r_gest;
    logic                                 r_pend_valid;
    bpgc_pkg::t_out                       r_pend;
    logic                                 r_out_valid;
    bpgc_pkg::t_out                       r_out;

    logic                                 in_take;
    logic                                 out_free;
    logic                                 out_load;
    logic [bpgc_pkg::TICK_W-1:0]          alu_a;
    logic [bpgc_pkg::TICK_W-1:0]          alu_b;
    logic [bpgc_pkg::TICK_W:0]            alu_diff;
    logic                                 alu_borrow;
    logic                                 free_found;
    logic [bpgc_pkg::SLOT_W-1:0]          free_slot;
    logic                                 slot_match;
    logic                                 press_we;

    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // shared subtractor: hold time and the three limit compares
    always_comb begin
        alu_a = r_now;
        alu_b = r_press_time[r_b];
        unique case (r_state)
            S_DEB: begin
                alu_a = r_held;
                alu_b = r_debounce;
            end
            S_SHORT: begin
                alu_a = r_short;
                alu_b = r_held;
            end
            S_LONG: begin
                alu_a = r_long;
                alu_b = r_held;
            end
            default: begin
                alu_a = r_now;
                alu_b = r_press_time[r_b];
            end
        endcase
    end

    assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_borrow = alu_diff[bpgc_pkg::TICK_W];

    // lowest free subscriber slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = bpgc_pkg::SUBSCRIBERS - 1; i >= 0; i--) begin
            if (!r_sub_valid[i]) begin
                free_found = 1'b1;
                free_slot  = bpgc_pkg::SLOT_W'(i);
            end
        end
    end

    assign slot_match = r_sub_valid[r_s] && (r_sub_button[r_s] == r_b);
    assign press_we   = (r_state == S_BTN) && r_changed[r_b] && !r_levels[r_b];

    // sequencer loads a new output beat
    assign out_load = out_free && ((r_state == S_SUB) ||
                                   (r_state == S_SCAN && slot_match && r_pend_valid) ||
                                   (r_state == S_FLUSH && r_pend_valid));

    // press timestamps, no reset
    always_ff @(posedge i_clk) begin
        if (press_we) begin
            r_press_time[r_b] <= r_now;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= bpgc_pkg::DEBOUNCE_RST;
            r_short    <= bpgc_pkg::SHORT_RST;
            r_long     <= bpgc_pkg::LONG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bpgc_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                bpgc_pkg::CFG_SHORT:    r_short    <= i_cfg_data;
                bpgc_pkg::CFG_LONG:     r_long     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer, subscriber table and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_last_levels <= '1;
            r_sub_valid   <= '0;
            for (int i = 0; i < bpgc_pkg::SUBSCRIBERS; i++) begin
                r_sub_button[i] <= '0;
            end
            r_b           <= '0;
            r_s           <= '0;
            r_pend_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // output beat: loaded by the sequencer, leaves when taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_now  <= i_in_data.now_ticks;
                        r_want <= i_in_data.button;
                        r_b    <= '0;
                        r_s    <= '0;
                        if (i_in_data.kind == bpgc_pkg::KIND_SUB) begin
                            r_state <= S_SUB;
                        end else begin
                            r_levels      <= i_in_data.pin_levels;
                            r_changed     <= i_in_data.pin_levels ^ r_last_levels;
                            r_last_levels <= i_in_data.pin_levels;
                            r_state       <= S_BTN;
                        end
                    end
                end

                S_SUB: begin
                    if (out_free) begin
                        r_out.pressed_button   <= 1'b0;
                        r_out.gesture          <= bpgc_pkg::GEST_SHORT;
                        r_out.last             <= 1'b1;
                        if (free_found) begin
                            r_sub_valid[free_slot]  <= 1'b1;
                            r_sub_button[free_slot] <= r_want;
                            r_out.reply_kind        <= bpgc_pkg::REPLY_GRANT;
                            r_out.slot              <= free_slot;
                        end else begin
                            r_out.reply_kind <= bpgc_pkg::REPLY_FULL;
                            r_out.slot       <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end

                S_BTN: begin
                    if (r_changed[r_b] && r_levels[r_b]) begin
                        r_state <= S_HELD;
                    end else if (r_b == LAST_BTN) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_b <= r_b + 1'b1;
                    end
                end

                S_HELD: begin
                    r_held  <= alu_diff[bpgc_pkg::TICK_W-1:0];
                    r_state <= S_DEB;
                end

                S_DEB: begin
                    if (!alu_borrow) begin
                        r_state <= S_SHORT;
                    end else if (r_b == LAST_BTN) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_b     <= r_b + 1'b1;
                        r_state <= S_BTN;
                    end
                end

                S_SHORT: begin
                    if (!alu_borrow) begin
                        r_gest  <= bpgc_pkg::GEST_SHORT;
                        r_s     <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_LONG;
                    end
                end

                S_LONG: begin
                    if (!alu_borrow) begin
                        r_gest  <= bpgc_pkg::GEST_LONG;
                        r_s     <= '0;
                        r_state <= S_SCAN;
                    end else if (r_b == LAST_BTN) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_b     <= r_b + 1'b1;
                        r_state <= S_BTN;
                    end
                end

                S_SCAN: begin
                    // a match waits while an older reply cannot move out
                    if (!(slot_match && r_pend_valid && !out_free)) begin
                        if (slot_match) begin
                            if (r_pend_valid) begin
                                r_out <= r_pend;
                            end
                            r_pend_valid              <= 1'b1;
                            r_pend.reply_kind         <= bpgc_pkg::REPLY_GESTURE;
                            r_pend.slot               <= r_s;
                            r_pend.pressed_button     <= r_b;
                            r_pend.gesture            <= r_gest;
                            r_pend.last               <= 1'b0;
                            r_sub_valid[r_s]          <= 1'b0;
                        end
                        if (r_s == LAST_SLOT) begin
                            r_s <= '0;
                            if (r_b == LAST_BTN) begin
                                r_state <= S_FLUSH;
                            end else begin
                                r_b     <= r_b + 1'b1;
                                r_state <= S_BTN;
                            end
                        end else begin
                            r_s <= r_s + bpgc_pkg::SLOT_W'(1);
                        end
                    end
                end

                S_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out.reply_kind     <= r_pend.reply_kind;
                        r_out.slot           <= r_pend.slot;
                        r_out.pressed_button <= r_pend.pressed_button;
                        r_out.gesture        <= r_pend.gesture;
                        r_out.last           <= 1'b1;
                        r_pend_valid         <= 1'b0;
                        r_state              <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // an accepted beat keeps the input stalled in the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_in_stall)
        else $error("input not stalled after an accepted beat");

    // no reply is held back once the sequencer is idle
    a_no_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending reply left behind in idle");

    // a reply still waiting while idle is the final one of its item
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_out_valid) |-> r_out.last)
        else $error("non-final reply waiting while idle");

    // a gesture reply names a slot whose subscription is gone
    a_gesture_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && slot_match && !(r_pend_valid && !out_free))
        |=> !r_sub_valid[$past(r_s)])
        else $error("notified slot still subscribed");

    // reset leaves the sequencer idle with no output beat
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_IDLE && !r_out_valid))
        else $error("state not cleared by reset");

endmodule
